>>> sv/flr_pkg.sv
// Shared types, constants and helper functions for the four-connected line rasterizer.
package flr_pkg;

  localparam int COORD_WIDTH     = 8;
  localparam int REG_WIDTH       = 8;
  localparam int COLOR_WIDTH     = 16;
  localparam int REG_INDEX_WIDTH = 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_WIDTH       = (COORD_WIDTH > REG_WIDTH) ? COORD_WIDTH : REG_WIDTH;
  localparam int PROD_WIDTH      = 2 * COORD_WIDTH;

  typedef logic [COORD_WIDTH-1:0]     coord_t;
  typedef logic [REG_WIDTH-1:0]       reg_t;
  typedef logic [COLOR_WIDTH-1:0]     color_t;
  typedef logic [REG_INDEX_WIDTH-1:0] reg_index_t;
  typedef logic [PROD_WIDTH-1:0]      prod_t;

  localparam reg_t MAX_X_RESET = reg_t'(127);
  localparam reg_t MAX_Y_RESET = reg_t'(159);

  localparam reg_index_t REG_MAX_X = reg_index_t'(0);
  localparam reg_index_t REG_MAX_Y = reg_index_t'(1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_REJECT,
    OP_STEP
  } op_t;

  typedef struct packed {
    op_t    op;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    color_t color;
  } cmd_item_t;

  typedef struct packed {
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
    logic   rejected;
  } result_t;

  function automatic logic exceeds(input coord_t c, input reg_t lim);
    logic [CMP_WIDTH-1:0] cw;
    logic [CMP_WIDTH-1:0] lw;
    begin
      cw = CMP_WIDTH'(c);
      lw = CMP_WIDTH'(lim);
      exceeds = cw > lw;
    end
  endfunction

  function automatic coord_t absdiff(input coord_t a, input coord_t b);
    absdiff = (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  function automatic coord_t toward(input coord_t c, input coord_t t);
    begin
      if (c < t) begin
        toward = coord_t'(c + coord_t'(1));
      end else if (c > t) begin
        toward = coord_t'(c - coord_t'(1));
      end else begin
        toward = c;
      end
    end
  endfunction

endpackage

>>> sv/four_connected_line_raster.sv
// Top level of the four-connected line rasterizer.
//
// Items arrive on the input channel (in_valid/in_ready) as commands. A load command
// (cmd = 0) latches the endpoints and color and checks them against max_x and max_y;
// a step command (cmd = 1) asks for the next pixel of a 4-connected walk to the end point.
// Every item gives exactly one result item on the output channel (out_valid/out_ready).
// The limit registers are written through cfg_write, cfg_index and cfg_data.
//
// An accepted item is written into a two-entry command queue, and the walker pops it
// into the result register whenever that register is empty or being read.
// One item per cycle is sustained while out_ready stays high: each pixel move is two
// small multiplies, a compare and an increment feeding the current-point registers.
// When the receiver stalls, the result register holds and the queue absorbs up to
// two more items before in_ready falls; the front end and the walker stall separately.
// Reset (synchronous, active high) empties the queue and output register, ends any
// line in progress, and sets max_x to 127 and max_y to 159.
module four_connected_line_raster (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  flr_pkg::reg_index_t cfg_index,
  input  flr_pkg::reg_t       cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  flr_pkg::coord_t     start_x,
  input  flr_pkg::coord_t     start_y,
  input  flr_pkg::coord_t     end_x,
  input  flr_pkg::coord_t     end_y,
  input  flr_pkg::color_t     color,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                pixel_valid,
  output flr_pkg::coord_t     pixel_x,
  output flr_pkg::coord_t     pixel_y,
  output flr_pkg::color_t     pixel_color,
  output logic                last_pixel,
  output logic                rejected
);

  flr_pkg::cmd_item_t front_item;
  flr_pkg::cmd_item_t head;
  flr_pkg::result_t   result;
  logic               q_full;
  logic               q_empty;
  logic               pop;

  flr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .color     (color),
    .item      (front_item)
  );

  flr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  flr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .result    (result)
  );

  assign in_ready    = !q_full;
  assign pixel_valid = result.pixel_valid;
  assign pixel_x     = result.pixel_x;
  assign pixel_y     = result.pixel_y;
  assign pixel_color = result.pixel_color;
  assign last_pixel  = result.last_pixel;
  assign rejected    = result.rejected;

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid survived reset.");

  a_reject_has_no_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(rejected && pixel_valid))
    else $error("A rejected load carried a pixel.");

  a_last_needs_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_pixel) |-> pixel_valid)
    else $error("Last-pixel flag set on a result without a pixel.");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!q_empty && (!out_valid || out_ready)))
    else $error("Walker took a command without room in the output register.");

endmodule

>>> sv/flr_front.sv
// Front end: limit registers and classification of incoming commands.
module flr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  flr_pkg::reg_index_t cfg_index,
  input  flr_pkg::reg_t       cfg_data,
  input  logic                cmd,
  input  flr_pkg::coord_t     start_x,
  input  flr_pkg::coord_t     start_y,
  input  flr_pkg::coord_t     end_x,
  input  flr_pkg::coord_t     end_y,
  input  flr_pkg::color_t     color,
  output flr_pkg::cmd_item_t  item
);

  flr_pkg::reg_t max_x;
  flr_pkg::reg_t max_y;
  logic          out_of_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= flr_pkg::MAX_X_RESET;
      max_y <= flr_pkg::MAX_Y_RESET;
    end else if (cfg_write) begin
      if (cfg_index == flr_pkg::REG_MAX_X) begin
        max_x <= cfg_data;
      end
      if (cfg_index == flr_pkg::REG_MAX_Y) begin
        max_y <= cfg_data;
      end
    end
  end

  assign out_of_range = flr_pkg::exceeds(start_x, max_x) || flr_pkg::exceeds(end_x, max_x) ||
                        flr_pkg::exceeds(start_y, max_y) || flr_pkg::exceeds(end_y, max_y);

  always_comb begin
    item.sx    = start_x;
    item.sy    = start_y;
    item.ex    = end_x;
    item.ey    = end_y;
    item.color = color;
    if (cmd == flr_pkg::CMD_STEP) begin
      item.op = flr_pkg::OP_STEP;
    end else if (out_of_range) begin
      item.op = flr_pkg::OP_REJECT;
    end else begin
      item.op = flr_pkg::OP_LOAD;
    end
  end

endmodule

>>> sv/flr_queue.sv
// Short queue of classified commands between the front end and the walker.
module flr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  flr_pkg::cmd_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output flr_pkg::cmd_item_t head
);

  flr_pkg::cmd_item_t                        entries [flr_pkg::QUEUE_DEPTH];
  logic [flr_pkg::QUEUE_PTR_WIDTH-1:0]       wr_ptr;
  logic [flr_pkg::QUEUE_PTR_WIDTH-1:0]       rd_ptr;
  logic [flr_pkg::QUEUE_CNT_WIDTH-1:0]       count;
  logic                                      do_push;
  logic                                      do_pop;

  localparam logic [flr_pkg::QUEUE_PTR_WIDTH-1:0] LAST_PTR =
    flr_pkg::QUEUE_PTR_WIDTH'(flr_pkg::QUEUE_DEPTH - 1);
  localparam logic [flr_pkg::QUEUE_CNT_WIDTH-1:0] FULL_COUNT =
    flr_pkg::QUEUE_CNT_WIDTH'(flr_pkg::QUEUE_DEPTH);

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> sv/flr_back.sv
// Back end: line walk state, one-pixel step logic and the output register.
module flr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  flr_pkg::cmd_item_t head,
  output logic               pop,
  input  logic               out_ready,
  output logic               out_valid,
  output flr_pkg::result_t   result
);

  logic            line_active;
  logic            first_pending;
  flr_pkg::coord_t cur_x;
  flr_pkg::coord_t cur_y;
  flr_pkg::coord_t origin_x;
  flr_pkg::coord_t origin_y;
  flr_pkg::coord_t target_x;
  flr_pkg::coord_t target_y;
  flr_pkg::color_t line_color;

  flr_pkg::coord_t  ax;
  flr_pkg::coord_t  ay;
  flr_pkg::coord_t  dx;
  flr_pkg::coord_t  dy;
  flr_pkg::prod_t   prod_ay_dx;
  flr_pkg::prod_t   prod_dy_ax;
  flr_pkg::coord_t  step_x;
  flr_pkg::coord_t  step_y;
  flr_pkg::coord_t  cur_x_next;
  flr_pkg::coord_t  cur_y_next;
  logic             at_end;
  flr_pkg::result_t result_next;

  assign pop = !q_empty && (!out_valid || out_ready);

  assign ax         = flr_pkg::absdiff(cur_x, origin_x);
  assign ay         = flr_pkg::absdiff(cur_y, origin_y);
  assign dx         = flr_pkg::absdiff(target_x, origin_x);
  assign dy         = flr_pkg::absdiff(target_y, origin_y);
  assign prod_ay_dx = flr_pkg::prod_t'(ay) * flr_pkg::prod_t'(dx);
  assign prod_dy_ax = flr_pkg::prod_t'(dy) * flr_pkg::prod_t'(ax);

  always_comb begin
    step_x = cur_x;
    step_y = cur_y;
    if (cur_y == target_y) begin
      step_x = flr_pkg::toward(cur_x, target_x);
    end else if (cur_x == target_x) begin
      step_y = flr_pkg::toward(cur_y, target_y);
    end else if (ax == '0 || prod_ay_dx > prod_dy_ax) begin
      step_x = flr_pkg::toward(cur_x, target_x);
    end else begin
      step_y = flr_pkg::toward(cur_y, target_y);
    end
  end

  assign cur_x_next = first_pending ? cur_x : step_x;
  assign cur_y_next = first_pending ? cur_y : step_y;
  assign at_end     = (cur_x_next == target_x) && (cur_y_next == target_y);

  always_comb begin
    result_next = '0;
    case (head.op)
      flr_pkg::OP_REJECT: begin
        result_next.rejected = 1'b1;
      end
      flr_pkg::OP_STEP: begin
        if (line_active) begin
          result_next.pixel_valid = 1'b1;
          result_next.pixel_x     = cur_x_next;
          result_next.pixel_y     = cur_y_next;
          result_next.pixel_color = line_color;
          result_next.last_pixel  = at_end;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active   <= 1'b0;
      first_pending <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (head.op)
          flr_pkg::OP_LOAD: begin
            line_active   <= 1'b1;
            first_pending <= 1'b1;
          end
          flr_pkg::OP_REJECT: begin
            line_active   <= 1'b0;
            first_pending <= 1'b0;
          end
          flr_pkg::OP_STEP: begin
            if (line_active) begin
              first_pending <= 1'b0;
              line_active   <= !at_end;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
      case (head.op)
        flr_pkg::OP_LOAD: begin
          origin_x   <= head.sx;
          origin_y   <= head.sy;
          target_x   <= head.ex;
          target_y   <= head.ey;
          cur_x      <= head.sx;
          cur_y      <= head.sy;
          line_color <= head.color;
        end
        flr_pkg::OP_STEP: begin
          if (line_active) begin
            cur_x <= cur_x_next;
            cur_y <= cur_y_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> tb/tb_four_connected_line_raster.sv
// Self-checking testbench for the four-connected line rasterizer with a pixel walk predictor.
module tb_four_connected_line_raster;
  timeunit 1ns;
  timeprecision 1ps;

  import flr_pkg::*;

  typedef struct packed {
    logic   cmd;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    color_t color;
  } line_cmd_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  reg_index_t cfg_index = REG_MAX_X;
  reg_t       cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       cmd = CMD_STEP;
  coord_t     start_x = '0;
  coord_t     start_y = '0;
  coord_t     end_x = '0;
  coord_t     end_y = '0;
  color_t     color = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       pixel_valid;
  coord_t     pixel_x;
  coord_t     pixel_y;
  color_t     pixel_color;
  logic       last_pixel;
  logic       rejected;

  four_connected_line_raster uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .color(color),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_valid(pixel_valid), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .pixel_color(pixel_color), .last_pixel(last_pixel), .rejected(rejected)
  );

  line_cmd_t line_cmds[$];
  result_t   awaited_pixels[$];
  int        queued_total = 0;
  int        pixels_seen = 0;
  int        mismatches = 0;
  bit        steady = 1'b0;
  int        tx_gap = 0;
  int        rx_hold = 0;
  line_cmd_t next_cmd;
  result_t   want;
  result_t   got;

  // Predicted walker state, starting from its post-reset values.
  reg_t   lim_x = MAX_X_RESET;
  reg_t   lim_y = MAX_Y_RESET;
  logic   walking = 1'b0;
  logic   start_due = 1'b0;
  coord_t px = '0;
  coord_t py = '0;
  coord_t ox = '0;
  coord_t oy = '0;
  coord_t tx = '0;
  coord_t ty = '0;
  color_t pen = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int span_of(input coord_t a, input coord_t b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  task automatic raster_step(input line_cmd_t c, output result_t r);
    int ax;
    int ay;
    int dx;
    int dy;
    r = '0;
    if (c.cmd == CMD_LOAD) begin
      if (c.sx > lim_x || c.ex > lim_x || c.sy > lim_y || c.ey > lim_y) begin
        walking = 1'b0;
        start_due = 1'b0;
        r.rejected = 1'b1;
      end else begin
        ox = c.sx;
        oy = c.sy;
        tx = c.ex;
        ty = c.ey;
        px = c.sx;
        py = c.sy;
        pen = c.color;
        walking = 1'b1;
        start_due = 1'b1;
      end
    end else if (walking) begin
      if (start_due) begin
        start_due = 1'b0;
      end else begin
        ax = span_of(px, ox);
        ay = span_of(py, oy);
        dx = span_of(tx, ox);
        dy = span_of(ty, oy);
        // A zero x offset counts as a steeper slope than any target, so x moves first.
        if (py == ty || (px != tx && (ax == 0 || ay * dx > dy * ax))) begin
          px = (tx > px) ? coord_t'(px + 1) : coord_t'(px - 1);
        end else begin
          py = (ty > py) ? coord_t'(py + 1) : coord_t'(py - 1);
        end
      end
      r.pixel_valid = 1'b1;
      r.pixel_x = px;
      r.pixel_y = py;
      r.pixel_color = pen;
      if (px == tx && py == ty) begin
        r.last_pixel = 1'b1;
        walking = 1'b0;
      end
    end
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic compare_field(input string name, input logic [15:0] seen,
                               input logic [15:0] wanted);
    if (seen !== wanted)
      flag_mismatch($sformatf("item %0d %s got 0x%0h expected 0x%0h",
                              pixels_seen, name, seen, wanted));
  endtask

  // Driver: offers queued commands and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        raster_step({cmd, start_x, start_y, end_x, end_y, color}, want);
        awaited_pixels.push_back(want);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (line_cmds.size() != 0) begin
          next_cmd = line_cmds.pop_front();
          cmd <= next_cmd.cmd;
          start_x <= next_cmd.sx;
          start_y <= next_cmd.sy;
          end_x <= next_cmd.ex;
          end_y <= next_cmd.ey;
          color <= next_cmd.color;
          in_valid <= 1'b1;
          tx_gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item and stalls the output side.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel, rejected};
        if (awaited_pixels.size() == 0) begin
          flag_mismatch($sformatf("result item %0d arrived with none expected",
                                  pixels_seen));
        end else begin
          want = awaited_pixels.pop_front();
          compare_field("pixel_valid", got.pixel_valid, want.pixel_valid);
          compare_field("pixel_x", got.pixel_x, want.pixel_x);
          compare_field("pixel_y", got.pixel_y, want.pixel_y);
          compare_field("pixel_color", got.pixel_color, want.pixel_color);
          compare_field("last_pixel", got.last_pixel, want.last_pixel);
          compare_field("rejected", got.rejected, want.rejected);
        end
        pixels_seen++;
        // Long hold-off so the input queue fills and in_ready drops.
        if (pixels_seen % 500 == 250) rx_hold = 90;
      end
      if (rx_hold > 0) rx_hold--;
      else if (!steady && $urandom_range(0, 3) == 0) rx_hold = idle_len();
      out_ready <= (rx_hold == 0);
    end
  end

  task automatic push_load(input int sx, input int sy, input int ex, input int ey,
                           input int col);
    line_cmds.push_back('{CMD_LOAD, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
                          color_t'(col)});
    queued_total++;
  endtask

  task automatic push_steps(input int n);
    repeat (n) begin
      line_cmds.push_back('{CMD_STEP, coord_t'($urandom_range(0, 255)),
                            coord_t'($urandom_range(0, 255)), coord_t'($urandom_range(0, 255)),
                            coord_t'($urandom_range(0, 255)), color_t'($urandom_range(0, 65535))});
      queued_total++;
    end
  endtask

  function automatic int pick_near(input int c, input int lim, input int reach);
    int lo;
    int hi;
    lo = (c > reach) ? c - reach : 0;
    hi = (c + reach < lim) ? c + reach : lim;
    return $urandom_range(hi, lo);
  endfunction

  task automatic queue_line();
    int sx;
    int sy;
    int ex;
    int ey;
    int reach;
    int n;
    int r;
    reach = ($urandom_range(0, 9) == 0) ? 40 : 6;
    sx = $urandom_range(int'(lim_x), 0);
    sy = $urandom_range(int'(lim_y), 0);
    if ($urandom_range(0, 7) == 0) sx = $urandom_range(0, 1) ? int'(lim_x) : 0;
    if ($urandom_range(0, 7) == 0) sy = $urandom_range(0, 1) ? int'(lim_y) : 0;
    ex = pick_near(sx, int'(lim_x), reach);
    ey = pick_near(sy, int'(lim_y), reach);
    n = ((ex > sx) ? ex - sx : sx - ex) + ((ey > sy) ? ey - sy : sy - ey) + 1;
    r = $urandom_range(0, 99);
    push_load(sx, sy, ex, ey, $urandom_range(0, 65535));
    // Mostly complete walks; some run past the end and some are cut short by the next load.
    if (r < 75) push_steps(n);
    else if (r < 85) push_steps(n + $urandom_range(1, 3));
    else push_steps($urandom_range(0, n - 1));
  endtask

  task automatic queue_phase(input int quota);
    int target;
    int r;
    target = queued_total + quota;
    while (queued_total < target) begin
      r = $urandom_range(0, 99);
      if (r < 85) queue_line();
      else if (r < 93) push_load($urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 65535));
      else push_steps($urandom_range(1, 3));
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (line_cmds.size() != 0 || in_valid || awaited_pixels.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limits(input reg_t x, input reg_t y);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_X;
    cfg_data <= x;
    @(posedge clk);
    cfg_index <= REG_MAX_Y;
    cfg_data <= y;
    @(posedge clk);
    cfg_write <= 1'b0;
    lim_x = x;
    lim_y = y;
    @(negedge clk);
  endtask

  initial begin
    int phase_x[8];
    int phase_y[8];
    int i;
    phase_x = '{127, 255, 0, 255, 0, -1, -1, 255};
    phase_y = '{159, 255, 0, 0, 255, -1, -1, 255};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines at the reset limits.
    push_steps(1);
    push_load(5, 5, 5, 5, 16'hFFFF);
    push_steps(2);
    push_load(128, 0, 0, 0, 16'h0001);
    push_load(0, 0, 3, 2, 16'h0000);
    push_steps(3);
    push_load(0, 0, 0, 160, 16'h8000);
    push_steps(1);
    push_load(127, 159, 125, 159, 16'hA5A5);
    push_steps(3);
    push_load(2, 7, 2, 4, 16'h5A5A);
    push_steps(2);
    push_load(10, 1, 7, 3, 16'h1234);
    push_steps(6);
    wait_quiet();
    push_load(255, 255, 255, 255, 16'hFFFF);
    push_steps(1);

    for (i = 0; i < 8; i++) begin
      wait_quiet();
      set_limits((phase_x[i] < 0) ? reg_t'($urandom_range(0, 255)) : reg_t'(phase_x[i]),
                 (phase_y[i] < 0) ? reg_t'($urandom_range(0, 255)) : reg_t'(phase_y[i]));
      steady = (i == 1 || i == 7);
      queue_phase(185);
    end

    wait_quiet();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("four_connected_line_raster verification clean");
    end else begin
      $display("four_connected_line_raster verification failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("four_connected_line_raster verification failed");
    $finish;
  end

endmodule
